// ===== src/rfat_pkg.sv =====
// Package for the relay-feedback autotuner: widths, register indexes, phase
// codes and the config and divider job types. No dependencies.
`default_nettype none
package rfat_pkg;
   localparam int GAIN_FRAC_BITS = 16;
   localparam logic [28:0] PI_Q27 = 29'd421657428;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_OK   = 2'd2;
   localparam logic [1:0] PH_FAIL = 2'd3;

   localparam logic [1:0] FAIL_NONE    = 2'd0;
   localparam logic [1:0] FAIL_INVALID = 2'd1;
   localparam logic [1:0] FAIL_TIMEOUT = 2'd2;
   localparam logic [1:0] FAIL_DISABLE = 2'd3;

   localparam logic [2:0] REG_RELAY   = 3'd0;
   localparam logic [2:0] REG_HYST    = 3'd1;
   localparam logic [2:0] REG_MINAMP  = 3'd2;
   localparam logic [2:0] REG_MINCYC  = 3'd3;
   localparam logic [2:0] REG_TIMEOUT = 3'd4;
   localparam logic [2:0] REG_KPLIM   = 3'd5;
   localparam logic [2:0] REG_KDFRAC  = 3'd6;

   typedef struct packed {
      logic [15:0] relay_level;
      logic [14:0] hysteresis;
      logic [14:0] min_amplitude;
      logic [15:0] min_cycles;
      logic [31:0] run_timeout_ms;
      logic [31:0] kp_limit;
      logic [15:0] kd_fraction;
   } cfg_type;

   // divider job: 128-bit dividend over 64-bit divisor
   typedef struct packed {
      logic         start;
      logic [127:0] dividend;
      logic [63:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== src/rfat_div.sv =====
// Shared restoring divider, one quotient bit per cycle, saturated to 32 bits.
// Depends on rfat_pkg.
`default_nettype none
module rfat_div import rfat_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_req_type      req,
   output div_rsp_type      rsp
);
   logic         busy_ff, busy_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] num_ff, num_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  den_ff, den_in;
   logic [32:0]  quo_ff, quo_in;
   logic         sat_ff, sat_in;
   logic         done_ff, done_in;
   logic [64:0]  shifted;
   logic [64:0]  diff;
   logic         ge;

   always_comb begin
      shifted = {rem_ff, num_ff[127]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         quo_in  = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[126:0], 1'b0};
         // the remainder stays below the divisor, so 64 bits hold it
         rem_in = ge ? diff[63:0] : shifted[63:0];
         quo_in = {quo_ff[31:0], ge};
         if (quo_ff[31]) sat_in = 1'b1;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   always_comb begin
      rsp.done     = done_ff;
      rsp.quotient = (sat_ff || quo_ff[32] || den_ff == 64'd0) ? 32'hFFFF_FFFF
                                                               : quo_ff[31:0];
   end
endmodule
`default_nettype wire

// ===== src/rfat_mul.sv =====
// Shared 32x32 multiplier with registered product.
// Depends on rfat_pkg.
`default_nettype none
module rfat_mul import rfat_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic      [63:0] p
);
   logic [63:0] p_ff;
   always_ff @(posedge clock) p_ff <= {32'd0, a} * {32'd0, b};
   assign p = p_ff;
endmodule
`default_nettype wire

// ===== src/rfat_csr.sv =====
// APB configuration registers of the autotuner.
// Depends on rfat_pkg.
`default_nettype none
module rfat_csr import rfat_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output cfg_type          cfg
);
   cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   assign idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            REG_RELAY:   cfg_in.relay_level    = pwdata[15:0];
            REG_HYST:    cfg_in.hysteresis     = pwdata[14:0];
            REG_MINAMP:  cfg_in.min_amplitude  = pwdata[14:0];
            REG_MINCYC:  cfg_in.min_cycles     = pwdata[15:0];
            REG_TIMEOUT: cfg_in.run_timeout_ms = pwdata;
            REG_KPLIM:   cfg_in.kp_limit       = pwdata;
            REG_KDFRAC:  cfg_in.kd_fraction    = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relay_level    <= 16'd256;
         cfg_ff.hysteresis     <= 15'd200;
         cfg_ff.min_amplitude  <= 15'd100;
         cfg_ff.min_cycles     <= 16'd5;
         cfg_ff.run_timeout_ms <= 32'd20000;
         cfg_ff.kp_limit       <= 32'd65536;
         cfg_ff.kd_fraction    <= 16'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_RELAY:   prdata = {16'd0, cfg_ff.relay_level};
         REG_HYST:    prdata = {17'd0, cfg_ff.hysteresis};
         REG_MINAMP:  prdata = {17'd0, cfg_ff.min_amplitude};
         REG_MINCYC:  prdata = {16'd0, cfg_ff.min_cycles};
         REG_TIMEOUT: prdata = cfg_ff.run_timeout_ms;
         REG_KPLIM:   prdata = cfg_ff.kp_limit;
         REG_KDFRAC:  prdata = {16'd0, cfg_ff.kd_fraction};
         default:     prdata = 32'd0;
      endcase
   end
   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== src/relay_feedback_pd_autotuner.sv =====
// Top level of the relay-feedback autotuner: sample sequencer, run state and
// gain computation on a shared multiplier and divider. Depends on rfat_pkg,
// rfat_csr, rfat_mul and rfat_div.
//  channel | ports    | handshake
//  request | req_*    | req_valid / req_ready
//  result  | rsp_*    | rsp_valid / rsp_ready
//  config  | csr_*    | APB read/write, pready tied high
//
// A sample outside a run passes through STEP and OUT, a running sample through
// STEP, M7 and M8 to OUT; the sample that starts a run passes STEP twice.
// A successful run end goes M1, M2, DKU, the divider wait in M3, M4, M5, M6, M9,
// M10 and the divider wait in DKD before OUT. The next request is taken once the
// result register is free. Reset is synchronous; all control state clears at once.
`default_nettype none
module relay_feedback_pd_autotuner import rfat_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_enable,
   input  wire logic signed [16:0] req_bearing,
   input  wire logic        [31:0] req_now_ms,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_drive_update,
   output logic signed      [16:0] rsp_drive,
   output logic             [1:0]  rsp_phase,
   output logic                    rsp_result_valid,
   output logic             [31:0] rsp_kp_gain,
   output logic             [31:0] rsp_kd_gain,
   output logic             [31:0] rsp_ku_gain,
   output logic                    rsp_kp_capped,
   output logic             [15:0] rsp_cycle_count,
   output logic             [1:0]  rsp_fail_reason,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic        [4:0]  csr_paddr,
   input  wire logic        [31:0] csr_pwdata,
   output logic             [31:0] csr_prdata,
   output logic                    csr_pready
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_STEP = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_DKU  = 4'd4;
   localparam logic [3:0] S_M3   = 4'd5;
   localparam logic [3:0] S_M4   = 4'd6;
   localparam logic [3:0] S_M5   = 4'd7;
   localparam logic [3:0] S_M6   = 4'd8;
   localparam logic [3:0] S_DKD  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;
   localparam logic [3:0] S_M7   = 4'd11;
   localparam logic [3:0] S_M8   = 4'd12;
   localparam logic [3:0] S_M9   = 4'd13;
   localparam logic [3:0] S_M10  = 4'd14;

   cfg_type cfg;
   assign csr_pready = 1'b1;

   rfat_csr u_csr (
      .clock(clock), .reset(reset), .psel(csr_psel), .penable(csr_penable),
      .pwrite(csr_pwrite), .paddr(csr_paddr), .pwdata(csr_pwdata),
      .prdata(csr_prdata), .cfg(cfg)
   );

   logic [3:0] st_ff, st_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] fail_ff, fail_in;
   logic en_prev_ff, en_prev_in, have_prev_ff, have_prev_in;
   logic seek_pos_ff, seek_pos_in, discard_ff, discard_in, relay_pos_ff, relay_pos_in;
   logic signed [15:0] prev_err_ff, prev_err_in, ppk_ff, ppk_in, npk_ff, npk_in;
   logic [31:0] start_t_ff, start_t_in, cross_t_ff, cross_t_in;
   logic [15:0] ptotal_ff, ptotal_in;
   logic [31:0] psum_ff, psum_in, asum_ff, asum_in;
   logic [31:0] kp_ff, kp_in, kd_ff, kd_in, ku_ff, ku_in;
   logic        capped_ff, capped_in;
   logic        req_en_ff, req_en_in;
   logic signed [15:0] err_ff, err_in;
   logic [31:0] now_ff, now_in;
   logic        rv_ff, rv_in, upd_ff, upd_in;
   logic signed [16:0] drv_ff, drv_in;
   logic [63:0] tmp_ff, tmp_in;
   logic [63:0] kden_ff, kden_in;
   logic [63:0] plo_ff, plo_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   div_req_type dreq;
   div_rsp_type drsp;

   rfat_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(mul_p));
   rfat_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // heading wrap on the incoming bearing, up to two full turns
   logic signed [17:0] b_ext, wrapped;
   always_comb begin
      b_ext = {req_bearing[16], req_bearing};
      if (b_ext > 18'sd54000)        wrapped = b_ext - 18'sd72000;
      else if (b_ext > 18'sd18000)   wrapped = b_ext - 18'sd36000;
      else if (b_ext < -18'sd54000)  wrapped = b_ext + 18'sd72000;
      else if (b_ext < -18'sd18000)  wrapped = b_ext + 18'sd36000;
      else                           wrapped = b_ext;
   end

   logic signed [15:0] h;
   logic [31:0] period;
   logic [16:0] pp;
   logic [32:0] s1, s2;
   logic        finish_ok;
   logic [34:0] amp_need;
   logic [33:0] kp_raw;
   logic [29:0] div5;
   logic [2:0]  rem5;

   always_comb begin
      st_in = st_ff; phase_in = phase_ff; fail_in = fail_ff;
      en_prev_in = en_prev_ff; have_prev_in = have_prev_ff;
      seek_pos_in = seek_pos_ff; discard_in = discard_ff; relay_pos_in = relay_pos_ff;
      prev_err_in = prev_err_ff; ppk_in = ppk_ff; npk_in = npk_ff;
      start_t_in = start_t_ff; cross_t_in = cross_t_ff; ptotal_in = ptotal_ff;
      psum_in = psum_ff; asum_in = asum_ff;
      kp_in = kp_ff; kd_in = kd_ff; ku_in = ku_ff; capped_in = capped_ff;
      req_en_in = req_en_ff; err_in = err_ff; now_in = now_ff;
      rv_in = rv_ff; upd_in = upd_ff; drv_in = drv_ff; tmp_in = tmp_ff;
      kden_in = kden_ff; plo_in = plo_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      dreq = '0;
      h = signed'({1'b0, cfg.hysteresis});
      period = now_ff - cross_t_ff;
      pp = 17'(32'(signed'(ppk_ff)) - 32'(signed'(npk_ff)));
      s1 = {1'b0, psum_ff} + {1'b0, period};
      s2 = {1'b0, asum_ff} + {16'd0, pp};
      amp_need = {ptotal_ff, 1'b0} * {4'd0, cfg.min_amplitude};
      finish_ok = ptotal_ff >= cfg.min_cycles;
      // 2*ku/5 from ku/5 by reciprocal product and the remainder's low bits
      div5 = mul_p[63:34];
      rem5 = ku_ff[2:0] - ({div5[0], 2'b00} + div5[2:0]);
      kp_raw = {3'd0, div5, 1'b0} + {33'd0, (rem5 >= 3'd3)};
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               req_en_in = req_enable;
               err_in = wrapped[15:0];
               now_in = req_now_ms;
               st_in = S_STEP;
            end
         end
         S_STEP: begin
            en_prev_in = req_en_ff;
            upd_in = 1'b0;
            drv_in = '0;
            st_in = S_OUT;
            if (req_en_ff && !en_prev_ff) begin
               relay_pos_in = 1'b1; prev_err_in = '0; have_prev_in = 1'b0;
               discard_in = 1'b1; ptotal_in = '0; ppk_in = '0; npk_in = '0;
               seek_pos_in = 1'b1; psum_in = '0; asum_in = '0;
               start_t_in = now_ff; cross_t_in = now_ff;
               phase_in = PH_RUN; fail_in = FAIL_NONE;
               kp_in = '0; kd_in = '0; ku_in = '0; capped_in = 1'b0;
               // pass the same sample again as the first running one
               st_in = S_STEP;
            end else if (phase_ff == PH_RUN && (req_en_ff || en_prev_ff)) begin
               upd_in = 1'b1;
               if (req_en_ff && (now_ff - start_t_ff < cfg.run_timeout_ms)) begin
                  st_in = S_M7;
               end else begin
                  fail_in = req_en_ff ? FAIL_TIMEOUT : FAIL_DISABLE;
                  if (!finish_ok) begin
                     phase_in = PH_FAIL;
                     kp_in = '0; kd_in = '0; ku_in = '0; capped_in = 1'b0;
                  end else if (ptotal_ff == 16'd0 || {3'd0, asum_ff} < amp_need
                               || psum_ff == 32'd0) begin
                     phase_in = PH_FAIL; fail_in = FAIL_INVALID;
                     kp_in = '0; kd_in = '0; ku_in = '0; capped_in = 1'b0;
                  end else begin
                     st_in = S_M1;
                  end
               end
            end else if (!req_en_ff) begin
               upd_in = 1'b1;
            end
         end
         S_M7: begin
            // one running relay sample
            upd_in = 1'b1;
            relay_pos_in = (err_ff > h) ? 1'b0 :
                           (err_ff < -h) ? 1'b1 : relay_pos_ff;
            prev_err_in = err_ff;
            if (!have_prev_ff) begin
               have_prev_in = 1'b1; ppk_in = err_ff; npk_in = err_ff;
            end else if (seek_pos_ff) begin
               if (err_ff > ppk_ff) ppk_in = err_ff;
               if (prev_err_ff > 0 && err_ff <= 0 &&
                   ((err_ff > ppk_ff) ? err_ff : ppk_ff) > h) begin
                  seek_pos_in = 1'b0; npk_in = err_ff;
               end
            end else begin
               if (err_ff < npk_ff) npk_in = err_ff;
               if (prev_err_ff < 0 && err_ff >= 0 &&
                   ((err_ff < npk_ff) ? err_ff : npk_ff) < -h) begin
                  cross_t_in = now_ff; ppk_in = err_ff; seek_pos_in = 1'b1;
                  if (period > 32'd50 && {15'd0, pp} >= {16'd0, cfg.min_amplitude, 1'b0}) begin
                     if (discard_ff) discard_in = 1'b0;
                     else begin
                        psum_in = s1[32] ? 32'hFFFF_FFFF : s1[31:0];
                        asum_in = s2[32] ? 32'hFFFF_FFFF : s2[31:0];
                        if (ptotal_ff != 16'hFFFF) ptotal_in = ptotal_ff + 16'd1;
                     end
                  end
               end
            end
            st_in = S_M8;
         end
         S_M8: begin
            drv_in = relay_pos_ff ? $signed({1'b0, cfg.relay_level})
                                  : -$signed({1'b0, cfg.relay_level});
            st_in = S_OUT;
         end
         S_M1: begin
            mul_a = {16'd0, cfg.relay_level}; mul_b = {16'd0, ptotal_ff};
            st_in = S_M2;
         end
         S_M2: begin
            // t = 25*R*n needs 37 bits; denominator S*PI27 next
            tmp_in = mul_p * 64'd25;
            mul_a = asum_ff; mul_b = {3'd0, PI_Q27};
            st_in = S_DKU;
         end
         S_DKU: begin
            dreq.start = 1'b1;
            dreq.dividend = {tmp_ff, 64'd0} >> (64 - (GAIN_FRAC_BITS + 24));
            dreq.divisor = mul_p;
            st_in = S_M3;
         end
         S_M3: begin
            // reciprocal of 5 for the proportional gain
            mul_a = drsp.quotient; mul_b = 32'hCCCC_CCCD;
            if (drsp.done) begin
               ku_in = drsp.quotient;
               st_in = S_M4;
            end
         end
         S_M4: begin
            capped_in = kp_raw > {2'd0, cfg.kp_limit};
            kp_in = (kp_raw > {2'd0, cfg.kp_limit}) ? cfg.kp_limit : kp_raw[31:0];
            mul_a = ku_ff; mul_b = {16'd0, cfg.kd_fraction};
            st_in = S_M5;
         end
         S_M5: begin
            // a = ku*kdf*3 fits 50 bits; split multiply by P
            tmp_in = mul_p * 64'd3;
            mul_a = {16'd0, ptotal_ff}; mul_b = 32'd1310720000;
            st_in = S_M6;
         end
         S_M6: begin
            kden_in = mul_p;
            mul_a = tmp_ff[31:0]; mul_b = psum_ff;
            st_in = S_M9;
         end
         S_M9: begin
            plo_in = mul_p;
            mul_a = {14'd0, tmp_ff[49:32]}; mul_b = psum_ff;
            st_in = S_M10;
         end
         S_M10: begin
            dreq.start = 1'b1;
            dreq.dividend = {32'd0, {mul_p, 32'd0} + {32'd0, plo_ff}};
            dreq.divisor = kden_ff;
            st_in = S_DKD;
         end
         S_DKD: begin
            if (drsp.done) begin
               kd_in = drsp.quotient;
               phase_in = PH_OK; fail_in = FAIL_NONE;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; phase_ff <= PH_IDLE; fail_ff <= FAIL_NONE;
         en_prev_ff <= 1'b0; have_prev_ff <= 1'b0; seek_pos_ff <= 1'b1;
         discard_ff <= 1'b1; relay_pos_ff <= 1'b1;
         prev_err_ff <= '0; ppk_ff <= '0; npk_ff <= '0;
         start_t_ff <= '0; cross_t_ff <= '0; ptotal_ff <= '0;
         psum_ff <= '0; asum_ff <= '0;
         kp_ff <= '0; kd_ff <= '0; ku_ff <= '0; capped_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; fail_ff <= fail_in;
         en_prev_ff <= en_prev_in; have_prev_ff <= have_prev_in;
         seek_pos_ff <= seek_pos_in; discard_ff <= discard_in;
         relay_pos_ff <= relay_pos_in;
         prev_err_ff <= prev_err_in; ppk_ff <= ppk_in; npk_ff <= npk_in;
         start_t_ff <= start_t_in; cross_t_ff <= cross_t_in; ptotal_ff <= ptotal_in;
         psum_ff <= psum_in; asum_ff <= asum_in;
         kp_ff <= kp_in; kd_ff <= kd_in; ku_ff <= ku_in; capped_ff <= capped_in;
         rv_ff <= rv_in;
      end
      req_en_ff <= req_en_in; err_ff <= err_in; now_ff <= now_in;
      upd_ff <= upd_in; drv_ff <= drv_in; tmp_ff <= tmp_in;
      kden_ff <= kden_in; plo_ff <= plo_in;
   end

   assign req_ready        = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid        = rv_ff;
   assign rsp_drive_update = upd_ff;
   assign rsp_drive        = drv_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_result_valid = phase_ff == PH_OK;
   assign rsp_kp_gain      = kp_ff;
   assign rsp_kd_gain      = kd_ff;
   assign rsp_ku_gain      = ku_ff;
   assign rsp_kp_capped    = capped_ff;
   assign rsp_cycle_count  = ptotal_ff;
   assign rsp_fail_reason  = fail_ff;
endmodule
`default_nettype wire

// ===== src/rfat_checker.sv =====
// Port-level checks on the autotuner, bound to the top level.
// Depends on rfat_pkg.
`default_nettype none
module rfat_checker import rfat_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_phase,
   input wire logic        rsp_result_valid,
   input wire logic [1:0]  rsp_fail_reason,
   input wire logic [31:0] rsp_ku_gain
);
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result held");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_valid == (rsp_phase == PH_OK)))
      else $error("result_valid mismatch");
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_FAIL |-> rsp_fail_reason != FAIL_NONE &&
      rsp_ku_gain == 32'd0) else $error("fail without reason");
endmodule

bind relay_feedback_pd_autotuner rfat_checker u_rfat_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_phase(rsp_phase), .rsp_result_valid(rsp_result_valid),
   .rsp_fail_reason(rsp_fail_reason), .rsp_ku_gain(rsp_ku_gain)
);
`default_nettype wire

// ===== tb/relay_feedback_pd_autotuner_checker.sv =====
// Checker for the relay-feedback autotuner: snoops register writes and requests,
// predicts each response and compares it field by field. Depends on rfat_pkg.
`timescale 1ns / 100ps
module relay_feedback_pd_autotuner_checker import rfat_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_enable,
   input  wire logic signed [16:0] req_bearing,
   input  wire logic        [31:0] req_now_ms,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_drive_update,
   input  wire logic signed [16:0] rsp_drive,
   input  wire logic        [1:0]  rsp_phase,
   input  wire logic               rsp_result_valid,
   input  wire logic        [31:0] rsp_kp_gain,
   input  wire logic        [31:0] rsp_kd_gain,
   input  wire logic        [31:0] rsp_ku_gain,
   input  wire logic               rsp_kp_capped,
   input  wire logic        [15:0] rsp_cycle_count,
   input  wire logic        [1:0]  rsp_fail_reason,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic        [4:0]  csr_paddr,
   input  wire logic        [31:0] csr_pwdata,
   input  wire logic               csr_pready,
   output int                      mismatches,
   output int                      pending
);
   typedef struct packed {
      logic               drive_update;
      logic signed [16:0] drive;
      logic [1:0]         phase;
      logic               result_valid;
      logic [31:0]        kp_gain;
      logic [31:0]        kd_gain;
      logic [31:0]        ku_gain;
      logic               kp_capped;
      logic [15:0]        cycle_count;
      logic [1:0]         fail_reason;
   } tuner_output_type;

   tuner_output_type expected_outputs[$];
   cfg_type cfg;

   logic [1:0]  run_phase, fail_code;
   bit          enable_prev, have_prev, seek_pos, discard_first, relay_pos;
   int          prev_err, pos_peak, neg_peak;
   logic [31:0] start_ms, cross_ms, period_sum, amp_sum;
   logic [15:0] periods;
   logic [31:0] kp, kd, ku;
   bit          capped;

   assign pending = expected_outputs.size();

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   function automatic int wrap_heading(input logic signed [16:0] bearing);
      int b;
      b = bearing;
      while (b > 18000) b -= 36000;
      while (b < -18000) b += 36000;
      return b;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
      logic [32:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] div_sat(input logic [127:0] num, input logic [127:0] den);
      logic [127:0] q;
      if (den == 0) return 32'hFFFF_FFFF;
      q = num / den;
      return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   task automatic clear_gains();
      kp = '0; kd = '0; ku = '0; capped = 0;
   endtask

   task automatic start_run(input logic [31:0] now);
      relay_pos = 1; prev_err = 0; have_prev = 0; discard_first = 1;
      periods = '0; pos_peak = 0; neg_peak = 0; seek_pos = 1;
      period_sum = '0; amp_sum = '0; start_ms = now; cross_ms = now;
      run_phase = PH_RUN; fail_code = FAIL_NONE;
      clear_gains();
   endtask

   task automatic fail_run(input logic [1:0] code);
      run_phase = PH_FAIL;
      fail_code = code;
      clear_gains();
   endtask

   task automatic finish_run(input logic [1:0] short_code);
      logic [63:0] kp_raw;
      if (periods < cfg.min_cycles) begin
         fail_run(short_code);
         return;
      end
      if (periods == 0 || 64'(amp_sum) < 64'(2) * periods * cfg.min_amplitude ||
          period_sum == 0) begin
         fail_run(FAIL_INVALID);
         return;
      end
      ku = div_sat((128'(cfg.relay_level) * 128'(25) * 128'(periods)) << (GAIN_FRAC_BITS + 24),
                   128'(amp_sum) * 128'(PI_Q27));
      kp_raw = (64'(ku) * 2) / 5;
      capped = kp_raw > 64'(cfg.kp_limit);
      kp = capped ? cfg.kp_limit : kp_raw[31:0];
      kd = div_sat(128'(ku) * 128'(cfg.kd_fraction) * 128'(3) * 128'(period_sum),
                   128'(20000) * 128'(periods) * 128'(65536));
      run_phase = PH_OK;
      fail_code = FAIL_NONE;
   endtask

   task automatic track_relay(input int err, input logic [31:0] now);
      int          h;
      logic [31:0] period;
      int          pp;
      h = cfg.hysteresis;
      if (err > h) relay_pos = 0;
      else if (err < -h) relay_pos = 1;
      if (!have_prev) begin
         prev_err = err; have_prev = 1; pos_peak = err; neg_peak = err;
         return;
      end
      if (seek_pos) begin
         if (err > pos_peak) pos_peak = err;
         if (prev_err > 0 && err <= 0 && pos_peak > h) begin
            seek_pos = 0;
            neg_peak = err;
         end
      end else begin
         if (err < neg_peak) neg_peak = err;
         if (prev_err < 0 && err >= 0 && neg_peak < -h) begin
            period = now - cross_ms;
            pp = pos_peak - neg_peak;
            cross_ms = now;
            pos_peak = err;
            seek_pos = 1;
            if (period > 50 && pp >= 2 * int'(cfg.min_amplitude)) begin
               if (discard_first) begin
                  discard_first = 0;
               end else begin
                  period_sum = sat_add(period_sum, period);
                  amp_sum = sat_add(amp_sum, pp);
                  if (periods != 16'hFFFF) periods++;
               end
            end
         end
      end
      prev_err = err;
   endtask

   task automatic predict_sample(input logic en, input logic signed [16:0] bearing,
                                 input logic [31:0] now);
      tuner_output_type o;
      bit rising, falling;
      rising = en && !enable_prev;
      falling = !en && enable_prev;
      o = '0;
      enable_prev = en;
      if (rising) start_run(now);
      if (run_phase == PH_RUN && en) begin
         o.drive_update = 1;
         if (now - start_ms >= cfg.run_timeout_ms) begin
            finish_run(FAIL_TIMEOUT);
         end else begin
            track_relay(wrap_heading(bearing), now);
            o.drive = relay_pos ? 17'(cfg.relay_level) : -17'(cfg.relay_level);
         end
      end else if (falling && run_phase == PH_RUN) begin
         o.drive_update = 1;
         finish_run(FAIL_DISABLE);
      end else if (!en) begin
         o.drive_update = 1;
      end
      o.phase = run_phase;
      o.result_valid = run_phase == PH_OK;
      o.kp_gain = kp;
      o.kd_gain = kd;
      o.ku_gain = ku;
      o.kp_capped = capped;
      o.cycle_count = periods;
      o.fail_reason = fail_code;
      expected_outputs.push_back(o);
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      tuner_output_type w;
      if (reset) begin
         cfg.relay_level = 256; cfg.hysteresis = 200; cfg.min_amplitude = 100;
         cfg.min_cycles = 5; cfg.run_timeout_ms = 20000; cfg.kp_limit = 65536;
         cfg.kd_fraction = 32768;
         enable_prev = 0;
         start_run('0);
         run_phase = PH_IDLE;
         expected_outputs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_RELAY:   cfg.relay_level = csr_pwdata[15:0];
               REG_HYST:    cfg.hysteresis = csr_pwdata[14:0];
               REG_MINAMP:  cfg.min_amplitude = csr_pwdata[14:0];
               REG_MINCYC:  cfg.min_cycles = csr_pwdata[15:0];
               REG_TIMEOUT: cfg.run_timeout_ms = csr_pwdata;
               REG_KPLIM:   cfg.kp_limit = csr_pwdata;
               REG_KDFRAC:  cfg.kd_fraction = csr_pwdata[15:0];
               default: ;
            endcase
         end
         // compare before pushing: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch("unexpected response", '0, '0);
            end else begin
               w = expected_outputs.pop_front();
               if (rsp_drive_update !== w.drive_update)
                  report_mismatch("drive_update", w.drive_update, rsp_drive_update);
               if (rsp_drive !== w.drive) report_mismatch("drive", w.drive, rsp_drive);
               if (rsp_phase !== w.phase) report_mismatch("phase", w.phase, rsp_phase);
               if (rsp_result_valid !== w.result_valid)
                  report_mismatch("result_valid", w.result_valid, rsp_result_valid);
               if (rsp_kp_gain !== w.kp_gain) report_mismatch("kp_gain", w.kp_gain, rsp_kp_gain);
               if (rsp_kd_gain !== w.kd_gain) report_mismatch("kd_gain", w.kd_gain, rsp_kd_gain);
               if (rsp_ku_gain !== w.ku_gain) report_mismatch("ku_gain", w.ku_gain, rsp_ku_gain);
               if (rsp_kp_capped !== w.kp_capped)
                  report_mismatch("kp_capped", w.kp_capped, rsp_kp_capped);
               if (rsp_cycle_count !== w.cycle_count)
                  report_mismatch("cycle_count", w.cycle_count, rsp_cycle_count);
               if (rsp_fail_reason !== w.fail_reason)
                  report_mismatch("fail_reason", w.fail_reason, rsp_fail_reason);
            end
         end
         if (req_valid && req_ready) predict_sample(req_enable, req_bearing, req_now_ms);
      end
   end
endmodule

// ===== tb/relay_feedback_pd_autotuner_tb.sv =====
// Top of the autotuner testbench: clock, reset, register setup, heading
// oscillation stimulus and verdict. Depends on rfat_pkg, the DUT and checker.
`timescale 1ns / 100ps
module relay_feedback_pd_autotuner_tb;
   import rfat_pkg::*;

   localparam int ITEM_TARGET = 1800;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 400;

   logic               clock, reset;
   logic               req_valid, req_ready, req_enable;
   logic signed [16:0] req_bearing;
   logic        [31:0] req_now_ms;
   logic               rsp_valid, rsp_ready, rsp_drive_update, rsp_result_valid;
   logic signed [16:0] rsp_drive;
   logic        [1:0]  rsp_phase, rsp_fail_reason;
   logic        [31:0] rsp_kp_gain, rsp_kd_gain, rsp_ku_gain;
   logic               rsp_kp_capped;
   logic        [15:0] rsp_cycle_count;
   logic               csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic        [4:0]  csr_paddr;
   logic        [31:0] csr_pwdata, csr_prdata;
   int                 mismatches, pending;

   int          sent, send_idle_pct, recv_idle_pct, stall_cycles;
   logic [31:0] clock_ms, timeout_ms;

   relay_feedback_pd_autotuner dut (.*);
   relay_feedback_pd_autotuner_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) rsp_ready <= $urandom_range(99) >= recv_idle_pct;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // starts and ends at a falling edge
   task automatic send_sample(input logic en, input int bearing, input logic [31:0] now);
      if (sent < ITEM_TARGET / 3) begin
         send_idle_pct = 18; recv_idle_pct = 56;
      end else if (sent < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 56; recv_idle_pct = 18;
      end else begin
         send_idle_pct = 0; recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_enable <= en;
      req_bearing <= 17'(bearing);
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {index, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (index == REG_TIMEOUT) timeout_ms = value;
   endtask

   task automatic load_settings(input logic [31:0] relay, hyst, min_amp, min_cyc,
                                input logic [31:0] tmo, kp_lim, kd_frac);
      wait_idle();
      write_reg(REG_RELAY, relay);
      write_reg(REG_HYST, hyst);
      write_reg(REG_MINAMP, min_amp);
      write_reg(REG_MINCYC, min_cyc);
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_KPLIM, kp_lim);
      write_reg(REG_KDFRAC, kd_frac);
   endtask

   // one run: disable, enable, triangle heading oscillation, then end it or not
   task automatic oscillation_run();
      int amp, half, step_ms, count, v, p, ending;
      amp = $urandom_range(150, 18000);
      half = $urandom_range(2, 9);
      step_ms = $urandom_range(4, 40);
      count = $urandom_range(15, 110);
      ending = $urandom_range(3);
      send_sample(0, 0, clock_ms);
      for (int i = 0; i < count; i++) begin
         clock_ms += step_ms + $urandom_range(3);
         p = (i + half / 2) % (2 * half);
         v = (p < half) ? -amp + 2 * amp * p / half : amp - 2 * amp * (p - half) / half;
         v += $urandom_range(60) - 30;
         if (v > 18000) v = 18000;
         if (v < -18000) v = -18000;
         // alias the heading by a full turn now and then
         if ($urandom_range(7) == 0) v = (v > 0) ? v - 36000 : v + 36000;
         send_sample(1, v, clock_ms);
      end
      if (ending == 0) begin
         clock_ms += timeout_ms;
         send_sample(1, 0, clock_ms);
      end
      if (ending != 3) send_sample(0, $urandom_range(72000) - 36000, clock_ms);
   endtask

   task automatic noise_samples();
      repeat ($urandom_range(1, 8))
         send_sample($urandom_range(1), $urandom_range(72000) - 36000, $urandom());
   endtask

   initial begin
      reset = 1;
      req_valid = 0; req_enable = 0; req_bearing = '0; req_now_ms = '0;
      rsp_ready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      sent = 0; stall_cycles = 0; send_idle_pct = 0; recv_idle_pct = 0;
      timeout_ms = 20000;
      clock_ms = $urandom();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // wrap edges, time extremes, enable edges in idle, run and fail phases
      send_sample(0, -36000, 32'h0);
      send_sample(0, 36000, 32'hFFFF_FFFF);
      send_sample(1, 18000, 32'hFFFF_FFF0);
      send_sample(1, -18000, 32'hFFFF_FFFF);
      send_sample(1, 18001, 32'h0000_0010);
      send_sample(1, -18001, 32'h0000_0040);
      send_sample(1, 0, 32'h0000_0080);
      send_sample(0, 0, 32'h0000_00C0);
      send_sample(0, 500, 32'h0000_0100);
      send_sample(1, -500, 32'h0000_0200);
      send_sample(1, 500, 32'h0000_6000);
      send_sample(1, 700, 32'h0000_6100);
      send_sample(0, -36000, 32'h0000_6200);

      for (int setting = 0; sent < ITEM_TARGET; setting++) begin
         if (setting == 1)
            load_settings(65535, 0, 0, 1, 32'hFFFF_FFFF, 0, 65535);
         else if (setting == 2)
            load_settings(0, 18000, 18000, 65535, 0, 32'hFFFF_FFFF, 0);
         else if (setting > 2)
            load_settings($urandom_range(65535), $urandom_range(50, 600),
                          $urandom_range(400), $urandom_range(1, 8),
                          $urandom_range(1500, 30000), $urandom(), $urandom_range(65535));
         repeat ((setting == 2) ? 2 : 5) begin
            if (sent < ITEM_TARGET) begin
               if ($urandom_range(9) == 0) noise_samples();
               else oscillation_run();
            end
         end
      end

      wait_idle();
      if (mismatches == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/rfat_pkg.sv
src/rfat_div.sv
src/rfat_mul.sv
src/rfat_csr.sv
src/relay_feedback_pd_autotuner.sv
src/rfat_checker.sv
tb/relay_feedback_pd_autotuner_checker.sv
tb/relay_feedback_pd_autotuner_tb.sv
